@@ rtl/sar_pkg.sv @@
// Shared types and constants for the sort-and-range-remove block.
// Used by every module of the block and by its checker; depends on nothing.
package sar_pkg;

	localparam int unsigned DEPTH  = 64;
	localparam int unsigned VAL_W  = 32;
	localparam int unsigned IDX_W  = $clog2(DEPTH);
	localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
	localparam int unsigned PAIR_W = VAL_W + IDX_W;
	localparam logic [VAL_W-1:0] SIGN_MASK = {1'b1, {(VAL_W-1){1'b0}}};

	typedef enum logic {
		OP_APPEND,
		OP_RUN
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK,
		STAT_NO_START,
		STAT_NO_END,
		STAT_EMPTY
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PASS,
		ST_DECIDE,
		ST_SCAN,
		ST_EMIT,
		ST_EMPTY
	} st_t;

	typedef struct packed {
		logic              command;
		logic signed [31:0] value;
		logic signed [31:0] range_start;
		logic signed [31:0] range_end;
	} item_t;

	typedef struct packed {
		logic signed [31:0] result_value;
		logic              last;
		logic              empty_res;
		status_t           status;
		logic              overflowed;
	} res_t;

	typedef struct packed {
		op_t              op;
		logic [VAL_W-1:0] value;
		logic [VAL_W-1:0] range_start;
		logic [VAL_W-1:0] range_end;
	} job_t;

endpackage

@@ rtl/sar_front.sv @@
// Front end: accepts command transactions, classifies them and holds them in a
// two-entry queue for the back end. Depends on sar_pkg.
module sar_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  sar_pkg::item_t  item,
	input  logic            pop,
	output logic            busy,
	output logic            job_valid,
	output sar_pkg::job_t   job
);

	sar_pkg::job_t q_q [2];
	sar_pkg::job_t job_in;
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    cnt_q;
	logic          push;

	assign busy      = (cnt_q == 2'd2);
	assign job_valid = (cnt_q != 2'd0);
	assign push      = start && !busy;
	assign job       = q_q[rd_ptr_q];

	always_comb begin
		job_in.op          = item.command ? sar_pkg::OP_RUN : sar_pkg::OP_APPEND;
		job_in.value       = item.value;
		job_in.range_start = item.range_start;
		job_in.range_end   = item.range_end;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wr_ptr_q] <= job_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

@@ rtl/sar_back.sv @@
// Back end: value store, range status pass and selection scan that emits the
// kept values in stable ascending order. Depends on sar_pkg.
module sar_back (
	input  logic           clk,
	input  logic           arst_n,
	input  sar_pkg::job_t  job,
	input  logic           job_valid,
	output logic           pop,
	output logic           strobe,
	output sar_pkg::res_t  result
);

	logic [sar_pkg::VAL_W-1:0]  mem [sar_pkg::DEPTH];

	sar_pkg::st_t               state_q, state_d;
	logic [sar_pkg::CNT_W-1:0]  count_q;
	logic                       ovf_q;
	logic [sar_pkg::CNT_W-1:0]  n_q;
	logic                       ovf_run_q;
	logic [sar_pkg::VAL_W-1:0]  ks_q, ke_q;
	logic                       have_ge_q, have_le_q;
	logic [sar_pkg::CNT_W-1:0]  in_cnt_q;
	sar_pkg::status_t           status_q;
	logic [sar_pkg::CNT_W-1:0]  kept_q;
	logic [sar_pkg::CNT_W-1:0]  emitted_q;
	logic [sar_pkg::CNT_W-1:0]  addr_q;
	logic                       rd_vld_s1;
	logic [sar_pkg::IDX_W-1:0]  rd_idx_s1;
	logic [sar_pkg::VAL_W-1:0]  rd_data_s1;
	logic [sar_pkg::PAIR_W-1:0] prev_q, best_q;
	logic                       prev_valid_q, best_valid_q;

	logic                       rd_go, rd_last, take, emit_last;
	logic                       is_append, is_run, store_full;
	logic [sar_pkg::VAL_W-1:0]  cand_key;
	logic [sar_pkg::PAIR_W-1:0] cand;
	logic                       ge_start, le_end, removed;
	sar_pkg::status_t           status_c;
	logic [sar_pkg::CNT_W-1:0]  kept_c;

	assign is_append  = (job.op == sar_pkg::OP_APPEND);
	assign is_run     = (job.op == sar_pkg::OP_RUN);
	assign store_full = (count_q == sar_pkg::CNT_W'(sar_pkg::DEPTH));

	assign rd_go    = ((state_q == sar_pkg::ST_PASS) || (state_q == sar_pkg::ST_SCAN))
		&& (addr_q < n_q);
	assign rd_last  = rd_vld_s1 && ({1'b0, rd_idx_s1} == (n_q - sar_pkg::CNT_W'(1)));
	assign cand_key = rd_data_s1 ^ sar_pkg::SIGN_MASK;
	assign cand     = {cand_key, rd_idx_s1};
	assign ge_start = (cand_key >= ks_q);
	assign le_end   = (cand_key <= ke_q);
	assign removed  = (status_q == sar_pkg::STAT_OK) && ge_start && le_end;
	assign take     = rd_vld_s1 && !removed
		&& (!prev_valid_q || (cand > prev_q))
		&& (!best_valid_q || (cand < best_q));
	assign emit_last = ((emitted_q + sar_pkg::CNT_W'(1)) == kept_q);

	always_comb begin
		if (!have_ge_q) begin
			status_c = sar_pkg::STAT_NO_START;
		end else if (!have_le_q) begin
			status_c = sar_pkg::STAT_NO_END;
		end else begin
			status_c = sar_pkg::STAT_OK;
		end
		kept_c = (status_c == sar_pkg::STAT_OK) ? (n_q - in_cnt_q) : n_q;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			sar_pkg::ST_IDLE: begin
				if (job_valid && is_run) begin
					state_d = (count_q == '0) ? sar_pkg::ST_EMPTY : sar_pkg::ST_PASS;
				end
			end
			sar_pkg::ST_PASS: begin
				if (rd_last) begin
					state_d = sar_pkg::ST_DECIDE;
				end
			end
			sar_pkg::ST_DECIDE: begin
				state_d = (kept_c == '0) ? sar_pkg::ST_EMPTY : sar_pkg::ST_SCAN;
			end
			sar_pkg::ST_SCAN: begin
				if (rd_last) begin
					state_d = sar_pkg::ST_EMIT;
				end
			end
			sar_pkg::ST_EMIT: begin
				state_d = emit_last ? sar_pkg::ST_IDLE : sar_pkg::ST_SCAN;
			end
			sar_pkg::ST_EMPTY: begin
				state_d = sar_pkg::ST_IDLE;
			end
			default: begin
				state_d = sar_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		pop                 = (state_q == sar_pkg::ST_IDLE) && job_valid;
		strobe              = 1'b0;
		result.result_value = '0;
		result.last         = 1'b0;
		result.empty_res    = 1'b0;
		result.status       = status_q;
		result.overflowed   = ovf_run_q;
		case (state_q)
			sar_pkg::ST_EMIT: begin
				strobe              = 1'b1;
				result.result_value = best_q[sar_pkg::PAIR_W-1 -: sar_pkg::VAL_W]
					^ sar_pkg::SIGN_MASK;
				result.last         = emit_last;
			end
			sar_pkg::ST_EMPTY: begin
				strobe           = 1'b1;
				result.last      = 1'b1;
				result.empty_res = 1'b1;
			end
			default: begin
				strobe = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop && is_append && !store_full) begin
			mem[count_q[sar_pkg::IDX_W-1:0]] <= job.value;
		end
		if (rd_go) begin
			rd_data_s1 <= mem[addr_q[sar_pkg::IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= sar_pkg::ST_IDLE;
			count_q      <= '0;
			ovf_q        <= 1'b0;
			addr_q       <= '0;
			rd_vld_s1    <= 1'b0;
			prev_valid_q <= 1'b0;
			best_valid_q <= 1'b0;
			emitted_q    <= '0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= rd_go;
			case (state_q)
				sar_pkg::ST_IDLE: begin
					addr_q <= '0;
					if (pop && is_append) begin
						if (store_full) begin
							ovf_q <= 1'b1;
						end else begin
							count_q <= count_q + sar_pkg::CNT_W'(1);
						end
					end
					if (pop && is_run) begin
						count_q <= '0;
						ovf_q   <= 1'b0;
					end
				end
				sar_pkg::ST_DECIDE: begin
					addr_q       <= '0;
					prev_valid_q <= 1'b0;
					best_valid_q <= 1'b0;
					emitted_q    <= '0;
				end
				sar_pkg::ST_SCAN: begin
					if (rd_go) begin
						addr_q <= addr_q + sar_pkg::CNT_W'(1);
					end
					if (take) begin
						best_valid_q <= 1'b1;
					end
				end
				sar_pkg::ST_EMIT: begin
					addr_q       <= '0;
					prev_valid_q <= 1'b1;
					best_valid_q <= 1'b0;
					emitted_q    <= emitted_q + sar_pkg::CNT_W'(1);
				end
				default: begin
					if (rd_go) begin
						addr_q <= addr_q + sar_pkg::CNT_W'(1);
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= addr_q[sar_pkg::IDX_W-1:0];
		case (state_q)
			sar_pkg::ST_IDLE: begin
				if (pop && is_run) begin
					n_q       <= count_q;
					ovf_run_q <= ovf_q;
					ks_q      <= job.range_start ^ sar_pkg::SIGN_MASK;
					ke_q      <= job.range_end ^ sar_pkg::SIGN_MASK;
					have_ge_q <= 1'b0;
					have_le_q <= 1'b0;
					in_cnt_q  <= '0;
					status_q  <= sar_pkg::STAT_EMPTY;
				end
			end
			sar_pkg::ST_PASS: begin
				if (rd_vld_s1) begin
					have_ge_q <= have_ge_q | ge_start;
					have_le_q <= have_le_q | le_end;
					if (ge_start && le_end) begin
						in_cnt_q <= in_cnt_q + sar_pkg::CNT_W'(1);
					end
				end
			end
			sar_pkg::ST_DECIDE: begin
				status_q <= status_c;
				kept_q   <= kept_c;
			end
			sar_pkg::ST_SCAN: begin
				if (take) begin
					best_q <= cand;
				end
			end
			sar_pkg::ST_EMIT: begin
				prev_q <= best_q;
			end
			default: begin
				prev_q <= prev_q;
			end
		endcase
	end

endmodule

@@ rtl/sort_and_range_remove.sv @@
// Append transactions are taken one per cycle while busy is low; a two-entry queue lets the
// front accept while the back works. A run makes a range status pass over the stored values,
// then a scan of the store and a result for each kept value, with the single-port store read
// once per cycle; an empty outcome gives a single result. Results cannot be stalled.
// Reset clears the queue, the stored count, the overflow flag and the sequencer; store contents
// are left as they are.
module sort_and_range_remove (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  sar_pkg::item_t item,
	output logic           strobe,
	output sar_pkg::res_t  result
);

	sar_pkg::job_t job;
	logic          job_valid;
	logic          pop;

	sar_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.item      (item),
		.pop       (pop),
		.busy      (busy),
		.job_valid (job_valid),
		.job       (job)
	);

	sar_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (job),
		.job_valid (job_valid),
		.pop       (pop),
		.strobe    (strobe),
		.result    (result)
	);

endmodule

@@ rtl/sar_checker.sv @@
// Port-level checks on the result transactions of sort_and_range_remove, and the
// bind that attaches them. Depends on sar_pkg.
module sar_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           strobe,
	input sar_pkg::res_t  result
);

	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.empty_res |-> result.last)
		else $error("Empty result transaction without last mark.");

	a_empty_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.empty_res |-> (result.result_value == 32'sd0))
		else $error("Empty result transaction carries a nonzero value.");

	a_store_empty: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (result.status == sar_pkg::STAT_EMPTY) |-> result.empty_res)
		else $error("Empty store reported with a value.");

	a_no_back_to_back_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.last |=> !strobe)
		else $error("Result transaction directly after the last one of a run.");

endmodule

bind sort_and_range_remove sar_checker u_sar_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.strobe (strobe),
	.result (result)
);

@@ dv/testbench.sv @@
// Self-checking testbench for sort_and_range_remove: directed and random append and run
// transactions, with every result checked against an in-bench model of sort and range removal.
// Depends on sar_pkg and the sort_and_range_remove RTL.
module testbench;

	localparam int unsigned IDLE_LIMIT = 2000;
	localparam int unsigned DRAIN_CYCLES = 300;
	localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] INT_MAX = 32'sh7fff_ffff;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	sar_pkg::item_t item = '0;
	logic strobe;
	sar_pkg::res_t result;

	logic signed [31:0] model_vals[sar_pkg::DEPTH];
	int unsigned model_count = 0;
	logic model_ovf = 1'b0;
	sar_pkg::res_t pending_results[$];
	sar_pkg::res_t want;
	int unsigned error_count = 0;
	int unsigned idle_pct = 0;
	int unsigned quiet_cycles = 0;
	int unsigned items_sent = 0;

	sort_and_range_remove u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.strobe(strobe),
		.result(result)
	);

	always #5 clk = ~clk;

	function automatic void sort_and_trim(input sar_pkg::item_t it);
		logic signed [31:0] sorted[sar_pkg::DEPTH];
		logic signed [31:0] v;
		int i, j, n, kept;
		logic have_ge, have_le;
		sar_pkg::status_t stat;
		sar_pkg::res_t r;
		if (it.command == sar_pkg::OP_APPEND) begin
			if (model_count < sar_pkg::DEPTH) begin
				model_vals[model_count] = it.value;
				model_count++;
			end else begin
				model_ovf = 1'b1;
			end
			return;
		end
		n = model_count;
		r = '0;
		r.overflowed = model_ovf;
		model_count = 0;
		model_ovf = 1'b0;
		if (n == 0) begin
			r.last = 1'b1;
			r.empty_res = 1'b1;
			r.status = sar_pkg::STAT_EMPTY;
			pending_results.push_back(r);
			return;
		end
		for (i = 0; i < n; i++) begin
			v = model_vals[i];
			j = i;
			while (j > 0 && sorted[j-1] > v) begin
				sorted[j] = sorted[j-1];
				j--;
			end
			sorted[j] = v;
		end
		have_ge = 1'b0;
		have_le = 1'b0;
		for (i = 0; i < n; i++) begin
			if (sorted[i] >= it.range_start) have_ge = 1'b1;
			if (sorted[i] <= it.range_end) have_le = 1'b1;
		end
		if (!have_ge) stat = sar_pkg::STAT_NO_START;
		else if (!have_le) stat = sar_pkg::STAT_NO_END;
		else stat = sar_pkg::STAT_OK;
		r.status = stat;
		kept = 0;
		for (i = 0; i < n; i++) begin
			if (stat == sar_pkg::STAT_OK && sorted[i] >= it.range_start
					&& sorted[i] <= it.range_end)
				continue;
			r.result_value = sorted[i];
			pending_results.push_back(r);
			kept++;
		end
		if (kept == 0) begin
			r.result_value = '0;
			r.last = 1'b1;
			r.empty_res = 1'b1;
			pending_results.push_back(r);
		end else begin
			pending_results[pending_results.size()-1].last = 1'b1;
		end
	endfunction

	function automatic sar_pkg::item_t append_item(input logic signed [31:0] v);
		sar_pkg::item_t it;
		it.command = sar_pkg::OP_APPEND;
		it.value = v;
		it.range_start = $urandom;
		it.range_end = $urandom;
		return it;
	endfunction

	function automatic sar_pkg::item_t run_item(input logic signed [31:0] lo,
			input logic signed [31:0] hi);
		sar_pkg::item_t it;
		it.command = sar_pkg::OP_RUN;
		it.value = $urandom;
		it.range_start = lo;
		it.range_end = hi;
		return it;
	endfunction

	function automatic logic signed [31:0] random_value();
		case ($urandom_range(9))
			0: return INT_MIN + $urandom_range(3);
			1: return INT_MAX - $urandom_range(3);
			2, 3, 4: return $signed($urandom_range(40)) - 20;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_item(input sar_pkg::item_t it);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		start <= 1'b1;
		item <= it;
		do @(posedge clk); while (busy);
		sort_and_trim(it);
		items_sent++;
	endtask

	task automatic wait_for_results();
		start <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	task automatic check_field(input string name, input logic [31:0] want_v,
			input logic [31:0] got_v);
		if (want_v !== got_v) begin
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want_v, got_v);
			error_count++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && strobe) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual %p", $time, result);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (!want.empty_res)
					check_field("result_value", want.result_value, result.result_value);
				check_field("last", 32'(want.last), 32'(result.last));
				check_field("empty_res", 32'(want.empty_res), 32'(result.empty_res));
				check_field("status", 32'(want.status), 32'(result.status));
				check_field("overflowed", 32'(want.overflowed), 32'(result.overflowed));
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || strobe) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic test_empty_store();
		send_item(run_item($urandom, $urandom));
	endtask

	task automatic test_extremes();
		send_item(append_item(INT_MIN));
		send_item(append_item(INT_MAX));
		send_item(append_item(0));
		send_item(append_item(-1));
		send_item(append_item(1));
		send_item(run_item(INT_MIN, -1));
	endtask

	task automatic test_range_status();
		send_item(append_item(10));
		send_item(append_item(-20));
		send_item(append_item(30));
		send_item(run_item(31, 100));
		send_item(append_item(10));
		send_item(append_item(-20));
		send_item(append_item(30));
		send_item(run_item(-100, -21));
		send_item(append_item(5));
		send_item(append_item(7));
		send_item(append_item(5));
		send_item(run_item(5, 7));
		send_item(append_item(INT_MIN));
		send_item(append_item(INT_MAX));
		send_item(append_item(7));
		send_item(run_item(INT_MAX, INT_MIN));
		send_item(append_item(9));
		send_item(append_item(-3));
		send_item(append_item(4));
		send_item(run_item(4, INT_MAX));
	endtask

	task automatic test_overflow();
		wait_for_results();
		repeat (sar_pkg::DEPTH + 2) send_item(append_item(random_value()));
		send_item(run_item($signed($urandom_range(20)) - 10, $signed($urandom_range(20))));
		send_item(run_item($urandom, $urandom));
	endtask

	task automatic random_sequences(input int unsigned n_items);
		logic signed [31:0] seen[$];
		logic signed [31:0] a, b, lo, hi;
		int unsigned n, stop_at;
		stop_at = items_sent + n_items;
		while (items_sent < stop_at) begin
			case ($urandom_range(19))
				0: n = 0;
				1: n = sar_pkg::DEPTH + $urandom_range(3);
				2, 3: n = $urandom_range(40, 11);
				default: n = $urandom_range(10, 1);
			endcase
			seen.delete();
			repeat (n) begin
				a = random_value();
				seen.push_back(a);
				send_item(append_item(a));
			end
			a = (seen.size() != 0) ? seen[$urandom_range(seen.size() - 1)] : random_value();
			b = (seen.size() != 0) ? seen[$urandom_range(seen.size() - 1)] : random_value();
			case ($urandom_range(7))
				0: begin lo = $urandom; hi = $urandom; end
				1: begin lo = b; hi = a; end
				2: begin lo = INT_MIN; hi = INT_MAX; end
				3: begin lo = a; hi = INT_MAX; end
				4: begin lo = INT_MIN; hi = a; end
				5: begin lo = a + 1; hi = $urandom; end
				default: begin lo = (a < b) ? a : b; hi = (a < b) ? b : a; end
			endcase
			if ($urandom_range(7) == 0) wait_for_results();
			send_item(run_item(lo, hi));
		end
	endtask

	task automatic test_random();
		idle_pct = 0;
		random_sequences(50);
		idle_pct = 56;
		random_sequences(50);
		idle_pct = 0;
		random_sequences(50);
		idle_pct = 19;
		random_sequences(50);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_store();
		test_extremes();
		test_range_status();
		test_overflow();
		test_random();
		wait_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) $display("Simulation PASSED");
		else $display("Simulation FAILED");
		$finish;
	end

endmodule
